// File: rtl/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared constants and types for the ASCII coordinate frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int COORD_W  = 32;
   localparam int TARGET_W = 2;
   localparam int COUNT_W  = 8;

   // longest frame in bytes, '$' included
   localparam logic [COUNT_W-1:0] MAX_FRAME = 8'd128;

   localparam logic [BYTE_W-1:0] CHAR_START = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] CHAR_END   = 8'h23;  // '#'
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;  // ','
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [BYTE_W-1:0] KIND_CIRCLE = 8'h4F; // 'O'
   localparam logic [BYTE_W-1:0] KIND_LASER  = 8'h4C; // 'L'
   localparam logic [BYTE_W-1:0] KIND_CROSS  = 8'h43; // 'C'

   localparam logic [TARGET_W-1:0] TARGET_CIRCLE = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_LASER  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_CROSS  = 2'd2;

   // position of the earliest '#' that closes a valid frame
   localparam logic [COUNT_W-1:0] MIN_END_POS = 8'd4;
   localparam logic [COUNT_W-1:0] KIND_POS    = 8'd1;
   localparam logic [COUNT_W-1:0] FIELD_POS   = 8'd3;

   typedef struct packed {
      logic                valid;
      logic [TARGET_W-1:0] target;
      logic [COORD_W-1:0]  x_value;
      logic [COORD_W-1:0]  y_value;
   } result_type;

endpackage

// File: rtl/ascii_coordinate_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_coordinate_frame_parser
// Streams ASCII bytes and reports circle, laser and cross coordinates.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle when the result side keeps up. A byte
// accepted from the bus sits in the input register, is parsed when the
// pipeline advances, and any result is loaded into the result register,
// which drives rsp_tvalid once the closing '#' has been parsed.
// While a result waits untaken the parser holds, and req_tready falls once
// the input register is also full. Frames are "$", type, separator, x,
// optional ",y", "#"; short, overlong and unknown-type frames give no result.
module ascii_coordinate_frame_parser import acfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] x_value, [63:32] y_value
   output logic [1:0]  rsp_tuser    // [1:0] target
);

   logic              byte_valid_ff, byte_valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              advance;
   logic              step_en;
   result_type        result;
   logic [COORD_W-1:0] x_value, y_value;

   // the pipeline moves whenever the result slot is free or being emptied
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !byte_valid_ff || advance;
   assign step_en    = byte_valid_ff && advance;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (req_tready) begin
         byte_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   acfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .in_byte (byte_ff),
      .result  (result)
   );

   acfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .target     (rsp_tuser),
      .x_value    (x_value),
      .y_value    (y_value)
   );

   assign rsp_tdata = {y_value, x_value};

endmodule

// File: rtl/acfp_parser.sv
// ----------------------------------------------------------------------------
// acfp_parser
// Frame state and number accumulators; one byte is consumed per step and
// a result is produced combinationally when a frame closes.
// ----------------------------------------------------------------------------
module acfp_parser import acfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] in_byte,
   output result_type        result
);

   localparam logic [2:0] PH_XSIGN = 3'd0;
   localparam logic [2:0] PH_XDIG  = 3'd1;
   localparam logic [2:0] PH_YSIGN = 3'd3;
   localparam logic [2:0] PH_YDIG  = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  kind_ff, kind_in;
   logic [2:0]         phase_ff, phase_in;
   logic [COORD_W-1:0] x_acc_ff, x_acc_in;
   logic               x_neg_ff, x_neg_in;
   logic [COORD_W-1:0] y_acc_ff, y_acc_in;
   logic               y_neg_ff, y_neg_in;

   logic               is_digit, is_sign, is_minus;
   logic [COORD_W-1:0] digit_val;
   logic [COORD_W-1:0] x_next_acc, y_next_acc;
   logic [COORD_W-1:0] x_signed, y_signed;

   // field parser results for this byte
   logic [2:0]         p_phase;
   logic [COORD_W-1:0] p_x_acc, p_y_acc;
   logic               p_x_neg, p_y_neg;

   assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign is_minus  = (in_byte == CHAR_MINUS);
   assign is_sign   = is_minus || (in_byte == CHAR_PLUS);
   assign digit_val = {{(COORD_W-4){1'b0}}, in_byte[3:0]};
   // acc * 10 + digit, wrapping
   assign x_next_acc = (x_acc_ff << 3) + (x_acc_ff << 1) + digit_val;
   assign y_next_acc = (y_acc_ff << 3) + (y_acc_ff << 1) + digit_val;
   assign x_signed   = x_neg_ff ? (~x_acc_ff + 32'd1) : x_acc_ff;
   assign y_signed   = y_neg_ff ? (~y_acc_ff + 32'd1) : y_acc_ff;

   always_comb begin
      p_phase = phase_ff;
      p_x_acc = x_acc_ff;
      p_y_acc = y_acc_ff;
      p_x_neg = x_neg_ff;
      p_y_neg = y_neg_ff;
      unique case (phase_ff)
         PH_XSIGN: begin
            if (is_sign) begin
               p_x_neg = is_minus;
               p_phase = PH_XDIG;
            end else if (is_digit) begin
               p_x_acc = x_next_acc;
               p_phase = PH_XDIG;
            end else if (in_byte == CHAR_COMMA) begin
               p_phase = PH_YSIGN;
            end else begin
               p_phase = PH_DONE;
            end
         end
         PH_XDIG: begin
            if (is_digit) begin
               p_x_acc = x_next_acc;
            end else if (in_byte == CHAR_COMMA) begin
               p_phase = PH_YSIGN;
            end else begin
               p_phase = PH_DONE;
            end
         end
         PH_YSIGN: begin
            if (is_sign) begin
               p_y_neg = is_minus;
               p_phase = PH_YDIG;
            end else if (is_digit) begin
               p_y_acc = y_next_acc;
               p_phase = PH_YDIG;
            end else begin
               p_phase = PH_DONE;
            end
         end
         PH_YDIG: begin
            if (is_digit) begin
               p_y_acc = y_next_acc;
            end else begin
               p_phase = PH_DONE;
            end
         end
         default: begin
            // done: ignore text until the closing byte
         end
      endcase
   end

   always_comb begin
      in_frame_in    = in_frame_ff;
      count_in       = count_ff;
      kind_in        = kind_ff;
      phase_in       = phase_ff;
      x_acc_in       = x_acc_ff;
      x_neg_in       = x_neg_ff;
      y_acc_in       = y_acc_ff;
      y_neg_in       = y_neg_ff;
      result.valid   = 1'b0;
      result.target  = TARGET_CIRCLE;
      result.x_value = x_signed;
      result.y_value = y_signed;

      if (kind_ff == KIND_LASER) begin
         result.target = TARGET_LASER;
      end else if (kind_ff == KIND_CROSS) begin
         result.target = TARGET_CROSS;
      end
      if (kind_ff != KIND_CIRCLE) begin
         result.x_value = {{(COORD_W-16){x_signed[15]}}, x_signed[15:0]};
         result.y_value = {{(COORD_W-16){y_signed[15]}}, y_signed[15:0]};
      end

      if (step_en) begin
         priority if (in_byte == CHAR_START) begin
            in_frame_in = 1'b1;
            count_in    = 8'd1;
            kind_in     = '0;
            phase_in    = PH_XSIGN;
            x_acc_in    = '0;
            x_neg_in    = 1'b0;
            y_acc_in    = '0;
            y_neg_in    = 1'b0;
         end else if (!in_frame_ff) begin
            // outside a frame: drop
         end else if (count_ff >= MAX_FRAME || in_byte == CHAR_END) begin
            // overlong frame drops this byte; a closing byte may emit
            if (count_ff < MAX_FRAME && count_ff >= MIN_END_POS) begin
               result.valid = (kind_ff == KIND_CIRCLE) || (kind_ff == KIND_LASER) ||
                              (kind_ff == KIND_CROSS);
            end
            in_frame_in = 1'b0;
            count_in    = '0;
            kind_in     = '0;
            phase_in    = PH_XSIGN;
            x_acc_in    = '0;
            x_neg_in    = 1'b0;
            y_acc_in    = '0;
            y_neg_in    = 1'b0;
         end else begin
            count_in = count_ff + 8'd1;
            if (count_ff == KIND_POS) begin
               kind_in = in_byte;
            end else if (count_ff >= FIELD_POS) begin
               phase_in = p_phase;
               x_acc_in = p_x_acc;
               x_neg_in = p_x_neg;
               y_acc_in = p_y_acc;
               y_neg_in = p_y_neg;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         kind_ff     <= '0;
         phase_ff    <= PH_XSIGN;
         x_acc_ff    <= '0;
         x_neg_ff    <= 1'b0;
         y_acc_ff    <= '0;
         y_neg_ff    <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         kind_ff     <= kind_in;
         phase_ff    <= phase_in;
         x_acc_ff    <= x_acc_in;
         x_neg_ff    <= x_neg_in;
         y_acc_ff    <= y_acc_in;
         y_neg_ff    <= y_neg_in;
      end
   end

endmodule

// File: rtl/acfp_out_reg.sv
// ----------------------------------------------------------------------------
// acfp_out_reg
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module acfp_out_reg import acfp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  result_type          result,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [TARGET_W-1:0] target,
   output logic [COORD_W-1:0]  x_value,
   output logic [COORD_W-1:0]  y_value
);

   logic                valid_ff, valid_in;
   logic [TARGET_W-1:0] target_ff;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         target_ff <= result.target;
         x_ff      <= result.x_value;
         y_ff      <= result.y_value;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign target     = target_ff;
   assign x_value    = x_ff;
   assign y_value    = y_ff;

endmodule
